// File: rtl/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int unsigned PAT_BYTES  = 32;  // widest pattern the registers hold
  localparam int unsigned LEN_W      = 6;   // pattern_len register width
  localparam int unsigned PIDX_W     = 5;   // index into the pattern bytes
  localparam int unsigned CFG_DATA_W = 64;  // widest configuration register
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_W      = 32;  // match_offset width

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0       = 3'd0,
    REG_PAT1       = 3'd1,
    REG_PAT2       = 3'd2,
    REG_PAT3       = 3'd3,
    REG_CARE       = 3'd4,
    REG_LEN        = 3'd5,
    REG_REPORT_ALL = 3'd6
  } cfg_reg_e;

  // Configuration as seen by the cells and the match logic.
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;         // effective length, 1 to cap
    logic                      report_all;
  } cfg_t;

endpackage

// File: rtl/wbps_if.sv
// Request and result channel interfaces of the pattern scanner.
interface wbps_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] mem_byte;
  logic       last_byte;

  modport source (output valid, mem_byte, last_byte, input ready);
  modport sink   (input valid, mem_byte, last_byte, output ready);
endinterface

interface wbps_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_offset;
  logic        is_match;
  logic        scan_end;

  modport source (output valid, match_offset, is_match, scan_end, input ready);
  modport sink   (input valid, match_offset, is_match, scan_end, output ready);
endinterface

// File: rtl/wbps_cfg.sv
// Configuration registers and effective pattern length.
module wbps_cfg
  import wbps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  localparam int unsigned CAP = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

  logic [3:0][CFG_DATA_W-1:0] pat_q;
  logic [PAT_BYTES-1:0]       care_q;
  logic [LEN_W-1:0]           len_q;
  logic                       all_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      care_q <= '1;
      len_q  <= LEN_W'(1);
      all_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PAT0:       pat_q[0] <= cfg_data_i;
        REG_PAT1:       pat_q[1] <= cfg_data_i;
        REG_PAT2:       pat_q[2] <= cfg_data_i;
        REG_PAT3:       pat_q[3] <= cfg_data_i;
        REG_CARE:       care_q   <= cfg_data_i[PAT_BYTES-1:0];
        REG_LEN:        len_q    <= cfg_data_i[LEN_W-1:0];
        REG_REPORT_ALL: all_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Zero length acts as one; a length above CAP (the smaller of PATTERN_MAX and PAT_BYTES) is clamped to CAP.
  always_comb begin
    cfg_o.pattern    = pat_q;
    cfg_o.care       = care_q;
    cfg_o.report_all = all_q;
    if (len_q == '0) begin
      cfg_o.len = LEN_W'(1);
    end else if (len_q > LEN_W'(CAP)) begin
      cfg_o.len = LEN_W'(CAP);
    end else begin
      cfg_o.len = len_q;
    end
  end

endmodule

// File: rtl/wbps_cell.sv
// One window cell: holds the byte of one age and checks the byte entering it against its pattern byte.
module wbps_cell
  import wbps_pkg::*;
#(
  parameter int unsigned AGE = 0,
  parameter int unsigned CAP = 32
) (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,   // byte entering this cell on a shift
  input  cfg_t       cfg_i,
  output logic [7:0] byte_o,
  output logic       ok_o      // entering byte is acceptable at this age
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  generate
    if (AGE < CAP) begin : g_cmp
      logic [LEN_W-1:0]  diff;
      logic [PIDX_W-1:0] pidx;
      // Age a lines up with pattern byte len-1-a.
      assign diff = cfg_i.len - LEN_W'(AGE) - LEN_W'(1);
      assign pidx = diff[PIDX_W-1:0];
      assign ok_o = (cfg_i.len <= LEN_W'(AGE)) || !cfg_i.care[pidx]
                 || (byte_i == cfg_i.pattern[pidx]);
    end else begin : g_idle
      assign ok_o = 1'b1;
    end
  endgenerate

endmodule

// File: rtl/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: cell row, counter and result register.
// A result appears on res_o in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the whole cell row compares the shifted window in the
//   accepting cycle, so the next byte may follow at once. A result held on res_o by a
//   stalled sink stops requests until it drains.
// Reset: byte counter, reported flag and result valid clear; configuration returns to its
//   defaults. Window bytes are not cleared; the byte counter keeps stale bytes out.
module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32,  // window depth in bytes, 2 to 64
  parameter int unsigned OFFSET_BITS = 32   // byte counter width, 16 to 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  wbps_req_if.sink              req_i,
  wbps_res_if.source            res_o
);

  localparam int unsigned CAP = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

  cfg_t cfg;

  wbps_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: take a request whenever the result register is free or drains now.
  logic req_acc;
  logic out_valid_q;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;

  // Cell row: cell k holds the byte of age k, all shift together on a request.
  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0]      cell_ok;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] in_byte;
    if (k == 0) begin : g_head
      assign in_byte = req_i.mem_byte;
    end else begin : g_body
      assign in_byte = win[k-1];
    end
    wbps_cell #(
      .AGE (k),
      .CAP (CAP)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (req_acc),
      .byte_i  (in_byte),
      .cfg_i   (cfg),
      .byte_o  (win[k]),
      .ok_o    (cell_ok[k])
    );
  end

  // Saturating count of bytes taken in the current range.
  localparam logic [OFFSET_BITS-1:0] SEEN_MAX = '1;

  logic [OFFSET_BITS-1:0] seen_q, seen_d, seen_inc;
  logic                   reported_q, reported_d;
  logic [OFFSET_BITS-1:0] len_ext;
  logic [OFFSET_BITS-1:0] off_full;
  logic [OUT_W-1:0]       off32;
  logic                   enough;
  logic                   hit;
  logic                   emit;

  assign seen_inc = (seen_q == SEEN_MAX) ? seen_q : seen_q + OFFSET_BITS'(1);
  assign len_ext  = OFFSET_BITS'(cfg.len);
  assign enough   = seen_inc >= len_ext;
  assign off_full = seen_inc - len_ext;

  // Offset beyond the output width sticks at all ones.
  if (OFFSET_BITS > OUT_W) begin : g_off_sat
    assign off32 = (|off_full[OFFSET_BITS-1:OUT_W]) ? '1 : off_full[OUT_W-1:0];
  end else begin : g_off_ext
    assign off32 = OUT_W'(off_full);
  end

  // First-only mode drops further matches once one is out for this range.
  assign hit  = (&cell_ok) && enough && (cfg.report_all || !reported_q);
  assign emit = hit || req_i.last_byte;

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (req_acc) begin
      if (req_i.last_byte) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        seen_d     = seen_inc;
        reported_d = reported_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // Result register.
  logic             out_valid_d;
  logic [OUT_W-1:0] off_q;
  logic             is_match_q;
  logic             scan_end_q;

  always_comb begin
    if (req_acc && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && emit) begin
      off_q      <= hit ? off32 : '0;
      is_match_q <= hit;
      scan_end_q <= req_i.last_byte;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.match_offset = off_q;
  assign res_o.is_match     = is_match_q;
  assign res_o.scan_end     = scan_end_q;

  // A shown result is either a match or the end of a range.
  a_res_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (is_match_q || scan_end_q))
    else $error("result with neither match nor scan end");

  // A no-match result carries a zero offset.
  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_match_q) |-> (off_q == '0))
    else $error("non-match result with nonzero offset");

  // The last byte of a range clears the range state.
  a_range_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.last_byte) |=> (seen_q == '0 && !reported_q))
    else $error("range state not cleared after last byte");

  // Counter advances by one per byte inside a range until it saturates.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && !req_i.last_byte && seen_q != SEEN_MAX)
      |=> (seen_q == $past(seen_q) + OFFSET_BITS'(1)))
    else $error("byte counter skipped");

endmodule

// File: bench/wbps_scan_sb_pkg.sv
// Scoreboard for the pattern scanner: predicts scan reports and checks them in order.
package wbps_scan_sb_pkg;
  import wbps_pkg::*;

  typedef struct packed {
    logic [31:0] match_offset;
    logic        is_match;
    logic        scan_end;
  } scan_report_t;

  class scan_scoreboard;
    logic [3:0][63:0] pattern_words;
    logic [31:0]      care_mask;
    logic [5:0]       pattern_len;
    bit               report_all;

    logic [7:0]       window [32];
    longint unsigned  bytes_seen;
    bit               match_reported;

    scan_report_t     due_reports [$];
    int unsigned      errors;

    function new();
      pattern_words  = '0;
      care_mask      = '1;
      pattern_len    = 6'd1;
      report_all     = 1'b0;
      foreach (window[i]) window[i] = 8'h00;
      bytes_seen     = 0;
      match_reported = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PAT0:       pattern_words[0] = val;
        REG_PAT1:       pattern_words[1] = val;
        REG_PAT2:       pattern_words[2] = val;
        REG_PAT3:       pattern_words[3] = val;
        REG_CARE:       care_mask = val[31:0];
        REG_LEN:        pattern_len = val[5:0];
        REG_REPORT_ALL: report_all = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      if (pattern_len == 0) return 1;
      if (pattern_len > 32) return 32;
      return pattern_len;
    endfunction

    function logic [7:0] pattern_byte(int unsigned i);
      return pattern_words[i >> 3][(i & 7) * 8 +: 8];
    endfunction

    // byte i of the pattern lines up with the byte that came n-1-i requests ago
    function bit window_hit(int unsigned n);
      if (bytes_seen < n) return 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        if (care_mask[i] && window[n - 1 - i] != pattern_byte(i)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic [7:0] mem_byte, bit last_byte);
      int unsigned     n;
      bit              hit;
      longint unsigned offset;
      scan_report_t    rep;
      for (int i = 31; i > 0; i--) window[i] = window[i - 1];
      window[0] = mem_byte;
      if (bytes_seen < 64'hFFFF_FFFF) bytes_seen++;
      n = eff_len();
      hit = window_hit(n);
      if (hit && !report_all && match_reported) hit = 1'b0;
      offset = 0;
      if (hit) begin
        offset = bytes_seen - n;
        if (offset > 64'hFFFF_FFFF) offset = 64'hFFFF_FFFF;
        match_reported = 1'b1;
      end
      if (hit || last_byte) begin
        rep.match_offset = hit ? offset[31:0] : 32'd0;
        rep.is_match     = hit;
        rep.scan_end     = last_byte;
        due_reports = {due_reports, rep};
      end
      if (last_byte) begin
        bytes_seen     = 0;
        match_reported = 1'b0;
      end
    endfunction

    function string show(scan_report_t r);
      return $sformatf("offset %0d match %0b end %0b", r.match_offset, r.is_match,
                       r.scan_end);
    endfunction

    function void check_report(scan_report_t got, longint unsigned stamp);
      scan_report_t want;
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected report, expected none, got %s", stamp, show(got));
        return;
      end
      want = due_reports.pop_front();
      if (got.match_offset !== want.match_offset || got.is_match !== want.is_match ||
          got.scan_end !== want.scan_end) begin
        errors++;
        $display("%0d ns: report mismatch, expected %s, got %s", stamp, show(want),
                 show(got));
      end
    endfunction
  endclass

endpackage

// File: bench/wildcard_byte_pattern_scanner_tb.sv
// Testbench for the wildcard byte pattern scanner: directed and random byte ranges.
module wildcard_byte_pattern_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;
  import wbps_scan_sb_pkg::*;

  // no register lives here; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_BYTES = 155;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  wbps_req_if req_if ();
  wbps_res_if res_if ();

  wildcard_byte_pattern_scanner uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  scan_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: ready toggles at random on falling edges.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Every accepted report is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_report('{res_if.match_offset, res_if.is_match, res_if.scan_end}, $time);
    end
  end

  // Watchdog: a run that stops moving is a failure, including predictions never met.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // leaving valid high so a back-to-back request needs no extra edge.
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mem_byte  <= b;
    req_if.last_byte <= last;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(b, last);
    @(negedge clk_i);
  endtask

  // Leaves write enable high; the caller drops it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Stop requests, wait for every predicted report, then let a byte that made no report
  // pass fully through the result register.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.due_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    int unsigned  phase;
    int unsigned  sent;
    int unsigned  rlen;
    int unsigned  n;
    int unsigned  sel;
    int unsigned  j;
    int unsigned  k;
    logic [7:0]   stream [$];
    logic [7:0]   inst [$];
    logic [5:0]   len_v;
    logic [31:0]  care_v;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.mem_byte  = 8'h00;
    req_if.last_byte = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_PAT0;
    cfg_data_i       = '0;
    src_idle_pct     = 9;
    sink_idle_pct    = 64;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Directed part ----
    // Reset config: one byte 0x00, must match, first match only.
    // Second 0x00 is a repeat match and stays silent; the last byte ends without a match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // one-byte range whose only byte matches: match and end in the same report
    send_byte(8'h00, 1'b1);
    settle();

    // Zero length acts as one; report-all gives a match on every byte.
    write_reg(REG_PAT0, '1);
    write_reg(REG_LEN, '0);
    write_reg(REG_REPORT_ALL, 64'd1);
    cfg_we_i <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // Oversized length clamps to 32; a short range never gets enough bytes.
    write_reg(REG_LEN, 64'd40);
    write_reg(REG_CARE, '0);
    cfg_we_i <= 1'b0;
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    settle();

    // Empty care mask: any two bytes match.
    write_reg(REG_LEN, 64'd2);
    cfg_we_i <= 1'b0;
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    settle();

    // FF ?? 00 in first-only mode; the unused index is hit with ones and must not matter.
    write_reg(REG_PAT0, 64'h0000_0000_0000_00FF);
    write_reg(REG_LEN, 64'd3);
    write_reg(REG_CARE, 64'h5);
    write_reg(REG_REPORT_ALL, '0);
    write_reg(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b1);

    // ---- Random phases ----
    for (phase = 0; phase < PHASES; phase++) begin
      // sender idles lightly first, then the receiver, then neither
      src_idle_pct  = (phase < 4) ? 9 : (phase < 8) ? 64 : 0;
      sink_idle_pct = (phase < 4) ? 64 : (phase < 8) ? 9 : 0;
      settle();

      sel = $urandom_range(15);
      case (sel)
        0:       len_v = 6'd0;
        1:       len_v = 6'($urandom_range(33, 63));
        2:       len_v = 6'd32;
        3:       len_v = 6'd1;
        4, 5, 6: len_v = 6'($urandom_range(9, 31));
        default: len_v = 6'($urandom_range(2, 8));
      endcase
      sel = $urandom_range(7);
      if (sel == 0) care_v = '0;
      else if (sel < 3) care_v = '1;
      else care_v = $urandom | $urandom;  // roughly one wildcard in four

      write_reg(REG_PAT0, {$urandom, $urandom});
      write_reg(REG_PAT1, {$urandom, $urandom});
      write_reg(REG_PAT2, {$urandom, $urandom});
      write_reg(REG_PAT3, {$urandom, $urandom});
      write_reg(REG_CARE, 64'(care_v));
      write_reg(REG_LEN, 64'(len_v));
      write_reg(REG_REPORT_ALL, 64'($urandom_range(1)));
      cfg_we_i <= 1'b0;

      n = sb.eff_len();
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // mostly short ranges, now and then a long one
        if ($urandom_range(7) == 0) rlen = $urandom_range(n, 4 * n + 40);
        else rlen = $urandom_range(1, 2 * n + 6);

        // ranges are built from whole pattern copies (wildcards random),
        // copies with one byte spoiled, and plain noise
        stream.delete();
        while (stream.size() < rlen) begin
          sel = $urandom_range(9);
          if (sel < 6) begin
            inst.delete();
            for (j = 0; j < n; j++)
              inst = {inst, sb.care_mask[j] ? sb.pattern_byte(j)
                                            : 8'($urandom_range(255))};
            if (sel == 5) begin
              j = $urandom_range(n - 1);
              inst[j] = inst[j] ^ 8'($urandom_range(1, 255));
            end
            foreach (inst[m]) stream = {stream, inst[m]};
          end else begin
            stream = {stream, 8'($urandom_range(255))};
          end
        end

        for (k = 0; k < stream.size(); k++)
          send_byte(stream[k], k == stream.size() - 1);
        sent += stream.size();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
